// File: design/rmeu_pkg.sv
// Shared types, opcodes and constants for the register machine execute unit.
package rmeu_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned IDX_W         = 4;
    localparam int unsigned REG_COUNT_DEF = 16;
    localparam int unsigned STEP_W        = 5;

    localparam logic [7:0] OP_WRITE = 8'h53;
    localparam logic [7:0] OP_MOV   = 8'h54;
    localparam logic [7:0] OP_MOVLI = 8'h55;
    localparam logic [7:0] OP_MOVHI = 8'h56;
    localparam logic [7:0] OP_ADD   = 8'h57;
    localparam logic [7:0] OP_ADDI  = 8'h58;
    localparam logic [7:0] OP_SUB   = 8'h59;
    localparam logic [7:0] OP_SUBI  = 8'h60;
    localparam logic [7:0] OP_MUL   = 8'h61;
    localparam logic [7:0] OP_MULI  = 8'h62;
    localparam logic [7:0] OP_DIV   = 8'h63;
    localparam logic [7:0] OP_DIVI  = 8'h64;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                start;
        alu_op_t             op;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic                done;
        logic [WORD_W-1:0]   result;
    } alu_rsp_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [WORD_W-1:0]   data;
    } rf_wr_t;

endpackage

// File: design/rmeu_regfile.sv
// Register file: memory with one write port, two registered read ports, valid bits.
module rmeu_regfile #(
    parameter int unsigned REG_COUNT = rmeu_pkg::REG_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [rmeu_pkg::IDX_W-1:0]  rd_a_idx,
    input  logic [rmeu_pkg::IDX_W-1:0]  rd_b_idx,
    output logic [rmeu_pkg::WORD_W-1:0] rd_a_data,
    output logic [rmeu_pkg::WORD_W-1:0] rd_b_data,
    input  rmeu_pkg::rf_wr_t            wr
);
    import rmeu_pkg::*;

    localparam int unsigned ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [WORD_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]    rd_a_data_reg;
    logic [WORD_W-1:0]    rd_b_data_reg;

    logic              a_hit;
    logic              b_hit;
    logic              w_hit;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ADDR_W-1:0] w_addr;

    // Indexes at or above the register count read as zero and drop writes.
    assign a_addr = rd_a_idx[ADDR_W-1:0];
    assign b_addr = rd_b_idx[ADDR_W-1:0];
    assign w_addr = wr.idx[ADDR_W-1:0];
    assign a_hit  = ({1'b0, rd_a_idx} < (IDX_W+1)'(REG_COUNT));
    assign b_hit  = ({1'b0, rd_b_idx} < (IDX_W+1)'(REG_COUNT));
    assign w_hit  = wr.en && ({1'b0, wr.idx} < (IDX_W+1)'(REG_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (w_hit)
        begin
            valid_reg[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_hit)
        begin
            mem[w_addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_data_reg <= (a_hit && valid_reg[a_addr]) ? mem[a_addr] : '0;
            rd_b_data_reg <= (b_hit && valid_reg[b_addr]) ? mem[b_addr] : '0;
        end
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule

// File: design/rmeu_alu.sv
// Shared iterative unit: one 33-bit adder for add, subtract, shift-add multiply, restoring divide.
module rmeu_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  rmeu_pkg::alu_req_t req,
    output rmeu_pkg::alu_rsp_t rsp
);
    import rmeu_pkg::*;

    alu_op_t           op_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] q_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [WORD_W-1:0] x_next;
    logic [WORD_W-1:0] y_next;
    logic [WORD_W-1:0] q_next;
    logic              last;

    logic [WORD_W:0]   add_x;
    logic [WORD_W:0]   add_y;
    logic              add_sub;
    logic [WORD_W+1:0] add_sum;

    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(WORD_W+1){add_sub}}}
                     + (WORD_W+2)'(add_sub);

    // One step of the selected operation through the shared adder.
    always_comb
    begin
        add_x   = {1'b0, x_reg};
        add_y   = {1'b0, y_reg};
        add_sub = 1'b0;
        x_next  = x_reg;
        y_next  = y_reg;
        q_next  = q_reg;
        last    = (cnt_reg == '1);
        case (op_reg)
            ALU_ADD:
            begin
                x_next = add_sum[WORD_W-1:0];
                last   = 1'b1;
            end
            ALU_SUB:
            begin
                add_sub = 1'b1;
                x_next  = add_sum[WORD_W-1:0];
                last    = 1'b1;
            end
            ALU_MUL:
            begin
                x_next = q_reg[0] ? add_sum[WORD_W-1:0] : x_reg;
                y_next = {y_reg[WORD_W-2:0], 1'b0};
                q_next = {1'b0, q_reg[WORD_W-1:1]};
            end
            ALU_DIV:
            begin
                // Trial subtract of the divisor from the shifted remainder.
                add_x   = {x_reg, q_reg[WORD_W-1]};
                add_sub = 1'b1;
                if (add_sum[WORD_W+1])
                begin
                    x_next = add_sum[WORD_W-1:0];
                    q_next = {q_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    x_next = {x_reg[WORD_W-2:0], q_reg[WORD_W-1]};
                    q_next = {q_reg[WORD_W-2:0], 1'b0};
                end
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_ADD;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= req.op;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last;
                cnt_reg  <= cnt_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= (req.op == ALU_MUL || req.op == ALU_DIV) ? '0 : req.a;
            y_reg <= req.b;
            q_reg <= req.a;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            q_reg <= q_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == ALU_DIV) ? q_reg : x_reg;

endmodule

// File: design/register_machine_execute_unit.sv
// Top level of the register machine execute unit: sequencer, output register, checks.
//
// The unit takes one 32-bit instruction per input beat (opcode [31:24], dest [23:20],
// src [19:16], reg/imm [15:0]) and runs it against a file of REG_COUNT 32-bit
// registers that read as zero after reset; valid bits per register give that, so
// there is no clearing pass. Register operands in the reg/imm field use only its
// low 4 bits, and indexes at or above REG_COUNT read zero and are not written.
// Arithmetic wraps modulo 2^32; divide by zero leaves all ones. WRITE returns the
// register's contents as a kind 0 result beat, an unknown opcode returns kind 1
// with value zero, and every other instruction returns no beat. One instruction is
// in flight at a time, and instr_stall stays high until it retires. Move, load
// immediate, add and subtract take a single step of the shared unit; multiply and
// divide run the 32 steps of the shared shift-add / restoring-divide unit; WRITE
// and unknown opcodes wait only while the previous result still sits stalled in
// the output register. A result beat waits in the output register and does not
// block the next instruction.
module register_machine_execute_unit #(
    parameter int unsigned REG_COUNT = rmeu_pkg::REG_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        instr_valid,
    output logic                        instr_stall,
    input  logic [rmeu_pkg::WORD_W-1:0] instruction,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        kind,
    output logic [rmeu_pkg::WORD_W-1:0] value
);
    import rmeu_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [WORD_W-1:0] instr_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_kind_reg;
    logic [WORD_W-1:0] out_value_reg;

    logic              in_fire;
    logic              emit_load;
    logic              emit_kind;
    logic [IDX_W-1:0]  rd_a_idx;
    logic [WORD_W-1:0] rd_a_data;
    logic [WORD_W-1:0] rd_b_data;
    logic [7:0]        opcode;
    logic [WORD_W-1:0] imm_ext;
    logic              alu_insn;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    rf_wr_t            rf_wr;

    assign in_fire = instr_valid && !instr_stall;
    assign opcode  = instr_reg[31:24];
    assign imm_ext = {16'h0000, instr_reg[15:0]};

    // WRITE reads its dest on port A; everything else reads src there.
    assign rd_a_idx = (instruction[31:24] == OP_WRITE) ? instruction[23:20]
                                                       : instruction[19:16];

    always_comb
    begin
        alu_insn = 1'b0;
        case (opcode) inside
            OP_MOV, OP_MOVLI, OP_MOVHI, OP_ADD, OP_ADDI, OP_SUB, OP_SUBI,
            OP_MUL, OP_MULI, OP_DIV, OP_DIVI:
                alu_insn = 1'b1;
            default:
                alu_insn = 1'b0;
        endcase
    end

    rmeu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_a_idx  (rd_a_idx),
        .rd_b_idx  (instruction[3:0]),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .wr        (rf_wr)
    );

    rmeu_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // Next state: decode in the cycle after the read, then execute or emit.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = alu_insn ? ST_EXEC : ST_EMIT;
            end
            ST_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: operand routing, writeback, result load.
    always_comb
    begin
        instr_stall   = (state_reg != ST_IDLE);
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        alu_req.a     = rd_a_data;
        alu_req.b     = rd_b_data;
        rf_wr.en      = 1'b0;
        rf_wr.idx     = instr_reg[23:20];
        rf_wr.data    = alu_rsp.result;
        emit_load     = 1'b0;
        emit_kind     = (opcode == OP_WRITE) ? KIND_WRITE : KIND_ERROR;
        case (state_reg)
            ST_DECODE:
            begin
                alu_req.start = alu_insn;
                case (opcode)
                    OP_MOV:
                    begin
                        alu_req.b = '0;
                    end
                    OP_MOVLI:
                    begin
                        alu_req.a = '0;
                        alu_req.b = imm_ext;
                    end
                    OP_MOVHI:
                    begin
                        alu_req.a = '0;
                        alu_req.b = {instr_reg[15:0], 16'h0000};
                    end
                    OP_ADDI:
                    begin
                        alu_req.b = imm_ext;
                    end
                    OP_SUB:
                    begin
                        alu_req.op = ALU_SUB;
                    end
                    OP_SUBI:
                    begin
                        alu_req.op = ALU_SUB;
                        alu_req.b  = imm_ext;
                    end
                    OP_MUL:
                    begin
                        alu_req.op = ALU_MUL;
                    end
                    OP_MULI:
                    begin
                        alu_req.op = ALU_MUL;
                        alu_req.b  = imm_ext;
                    end
                    OP_DIV:
                    begin
                        alu_req.op = ALU_DIV;
                    end
                    OP_DIVI:
                    begin
                        alu_req.op = ALU_DIV;
                        alu_req.b  = imm_ext;
                    end
                    default:
                    begin
                        alu_req.op = ALU_ADD;
                    end
                endcase
            end
            ST_EXEC:
            begin
                rf_wr.en = alu_rsp.done;
            end
            ST_EMIT:
            begin
                // Hold until the output register is free or drains this cycle.
                emit_load = !out_valid_reg || !result_stall;
            end
            default:
            begin
                emit_load = 1'b0;
            end
        endcase
    end

    assign out_valid_next = emit_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            instr_reg <= instruction;
        end
        if (emit_load)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= (emit_kind == KIND_WRITE) ? rd_a_data : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign value        = out_value_reg;

    // An accepted instruction always moves to decode on the next edge.
    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_DECODE))
        else $error("accepted instruction did not enter decode");

    // Writeback only retires from the execute state.
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> (state_reg == ST_EXEC))
        else $error("register write outside execute");

    // The shared unit only finishes while the sequencer waits on it.
    a_done_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == ST_EXEC))
        else $error("unit finished with no instruction waiting");

    // Error beats carry a zero value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind == KIND_ERROR)) |-> (value == '0))
        else $error("error result with nonzero value");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the register machine execute unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmeu_pkg::*;

    localparam int unsigned REG_COUNT    = REG_COUNT_DEF;
    localparam int          ITEMS_PER_PH = 417;
    localparam int          SETTLE_CYC   = 40;  // longer than a multiply/divide takes

    typedef struct packed {
        logic              res_kind;
        logic [WORD_W-1:0] res_value;
    } result_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        bit                typed;
        result_t           want;
    } stim_row_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              instr_valid  = 1'b0;
    logic              instr_stall;
    logic [WORD_W-1:0] instruction  = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              kind;
    logic [WORD_W-1:0] value;

    // Shadow register file and the results still owed by the block, oldest first.
    logic [WORD_W-1:0] reg_shadow [16];
    result_t           pending_results [$];
    stim_row_t         directed_rows [$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    register_machine_execute_unit #(
        .REG_COUNT(REG_COUNT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_stall  (instr_stall),
        .instruction  (instruction),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .value        (value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up after a fixed time, far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [WORD_W-1:0] encode(input logic [7:0] op, input logic [3:0] dst,
                                                 input logic [3:0] src, input logic [15:0] imm);
        return {op, dst, src, imm};
    endfunction

    // Execute one instruction against the shadow file; returns 1 when it emits a beat.
    function automatic bit execute_instr(input logic [WORD_W-1:0] word, output result_t res);
        logic [7:0]        op;
        logic [3:0]        dst;
        logic [3:0]        src;
        logic [3:0]        rsel;
        logic [WORD_W-1:0] immx;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] wr;
        bit                emits;
        op    = word[31:24];
        dst   = word[23:20];
        src   = word[19:16];
        rsel  = word[3:0];   // register operand: low 4 bits of the reg/imm field only
        immx  = {16'h0000, word[15:0]};
        a     = (src < REG_COUNT) ? reg_shadow[src] : '0;
        r     = (rsel < REG_COUNT) ? reg_shadow[rsel] : '0;
        wr    = '0;
        emits = 1'b0;
        res   = '0;
        case (op)
            OP_WRITE:
            begin
                emits = 1'b1;
                res   = '{KIND_WRITE, (dst < REG_COUNT) ? reg_shadow[dst] : '0};
            end
            OP_MOV:   wr = a;
            OP_MOVLI: wr = immx;
            OP_MOVHI: wr = {word[15:0], 16'h0000};
            OP_ADD:   wr = a + r;
            OP_ADDI:  wr = a + immx;
            OP_SUB:   wr = a - r;
            OP_SUBI:  wr = a - immx;
            OP_MUL:   wr = a * r;
            OP_MULI:  wr = a * immx;
            OP_DIV:   wr = (r == '0) ? '1 : a / r;
            OP_DIVI:  wr = (immx == '0) ? '1 : a / immx;
            default:
            begin
                emits = 1'b1;
                res   = '{KIND_ERROR, '0};
            end
        endcase
        if (!emits && dst < REG_COUNT)
            reg_shadow[dst] = wr;
        return emits;
    endfunction

    function automatic logic [WORD_W-1:0] random_instr();
        logic [7:0]  op;
        logic [15:0] imm;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // unknown opcodes: below, inside and above the defined range
            case ($urandom_range(0, 2))
                0:       op = 8'($urandom_range(8'h00, 8'h52));
                1:       op = 8'($urandom_range(8'h5A, 8'h5F));
                default: op = 8'($urandom_range(8'h65, 8'hFF));
            endcase
        end
        else if (pick < 30)
            op = OP_WRITE;
        else
        begin
            case ($urandom_range(0, 10))
                0:       op = OP_MOV;
                1:       op = OP_MOVLI;
                2:       op = OP_MOVHI;
                3:       op = OP_ADD;
                4:       op = OP_ADDI;
                5:       op = OP_SUB;
                6:       op = OP_SUBI;
                7:       op = OP_MUL;
                8:       op = OP_MULI;
                9:       op = OP_DIV;
                default: op = OP_DIVI;
            endcase
        end
        // favor tiny immediates now and then so divide-by-zero and small divisors show up
        imm = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        return encode(op, 4'($urandom), 4'($urandom), imm);
    endfunction

    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic table_row(input logic [WORD_W-1:0] word, input bit typed,
                             input logic k, input logic [WORD_W-1:0] v);
        stim_row_t row;
        row.word  = word;
        row.typed = typed;
        row.want  = '{k, v};
        directed_rows.push_back(row);
    endtask

    // Present one instruction beat and hold it until accepted, then record what it owes.
    task automatic send_beat(input logic [WORD_W-1:0] word, input bit typed, input result_t want);
        result_t predicted;
        bit      emits;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr_valid <= 1'b1;
        instruction <= word;
        do
            @(posedge clk);
        while (instr_stall);
        emits = execute_instr(word, predicted);
        if (emits)
            pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drop valid and hold off until every owed result beat has come back.
    task automatic drain();
        instr_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Receiver: check each accepted result beat, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("result beat kind=%0d value=%08h with nothing owed",
                                        kind, value));
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.res_kind)
                    flag_mismatch($sformatf("kind %0d, predicted %0d", kind, want.res_kind));
                if (value !== want.res_value)
                    flag_mismatch($sformatf("value %08h, predicted %08h",
                                            value, want.res_value));
            end
        end
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial
    begin
        result_t none;
        none = '0;
        foreach (reg_shadow[i])
            reg_shadow[i] = '0;

        // Directed table. Typed rows carry a result readable at a glance; the rest
        // are checked against the shadow model.
        table_row(encode(OP_WRITE, 4'd0,  4'd0, 16'h0000), 1, KIND_WRITE, 32'h0000_0000);
        table_row(encode(OP_WRITE, 4'd15, 4'd0, 16'h0000), 1, KIND_WRITE, 32'h0000_0000);
        table_row(encode(OP_MOVLI, 4'd1,  4'd0, 16'hFFFF), 0, KIND_WRITE, '0);
        table_row(encode(OP_MOVHI, 4'd2,  4'd0, 16'hFFFF), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd2,  4'd0, 16'h0000), 1, KIND_WRITE, 32'hFFFF_0000);
        // upper 12 bits of the register operand field are ignored: selects r1
        table_row(encode(OP_ADD,   4'd3,  4'd2, 16'hFFF1), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd3,  4'd0, 16'h0000), 1, KIND_WRITE, 32'hFFFF_FFFF);
        table_row(encode(OP_ADDI,  4'd4,  4'd3, 16'h0001), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd4,  4'd0, 16'h0000), 1, KIND_WRITE, 32'h0000_0000);
        table_row(encode(OP_SUBI,  4'd5,  4'd4, 16'h0001), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd5,  4'd0, 16'h0000), 1, KIND_WRITE, 32'hFFFF_FFFF);
        table_row(encode(OP_SUB,   4'd6,  4'd0, 16'hABC1), 0, KIND_WRITE, '0);
        table_row(encode(OP_MUL,   4'd7,  4'd3, 16'h0003), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd7,  4'd0, 16'h0000), 1, KIND_WRITE, 32'h0000_0001);
        table_row(encode(OP_MULI,  4'd8,  4'd3, 16'hFFFF), 0, KIND_WRITE, '0);
        // divide by zero, register and immediate forms
        table_row(encode(OP_DIV,   4'd9,  4'd3, 16'h0000), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd9,  4'd0, 16'h0000), 1, KIND_WRITE, 32'hFFFF_FFFF);
        table_row(encode(OP_DIVI,  4'd10, 4'd0, 16'h0000), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd10, 4'd0, 16'h0000), 1, KIND_WRITE, 32'hFFFF_FFFF);
        table_row(encode(OP_DIVI,  4'd11, 4'd3, 16'hFFFF), 0, KIND_WRITE, '0);
        table_row(encode(OP_MOV,   4'd12, 4'd11, 16'h0000), 0, KIND_WRITE, '0);
        table_row(encode(OP_WRITE, 4'd12, 4'd0, 16'h0000), 0, KIND_WRITE, '0);
        // unknown opcodes at both ends and in the gap between SUB and SUBI
        table_row(32'h0000_0000,                          1, KIND_ERROR, 32'h0000_0000);
        table_row(32'hFFFF_FFFF,                          1, KIND_ERROR, 32'h0000_0000);
        table_row(encode(8'h5A,    4'd1,  4'd1, 16'h1234), 1, KIND_ERROR, 32'h0000_0000);

        send_idle_pct  = 29;
        recv_stall_pct = 82;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        drain();

        // Three traffic profiles: slow receiver, slow sender, then full rate.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 29 : (ph == 1) ? 82 : 0;
            recv_stall_pct = (ph == 0) ? 82 : (ph == 1) ? 29 : 0;
            for (int n = 0; n < ITEMS_PER_PH; n++)
            begin
                send_beat(random_instr(), 0, none);
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
            drain();
        end

        repeat (SETTLE_CYC) @(posedge clk);

        $display("Sent %0d instructions (%0d from the directed table) over three traffic profiles;",
                 items_sent, directed_rows.size());
        $display("checked %0d result beats, %0d mismatches.", results_checked, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/rmeu_pkg.sv
design/rmeu_regfile.sv
design/rmeu_alu.sv
design/register_machine_execute_unit.sv
dv/testbench.sv
